FILE: rtl/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants of the frame delivery statistics block
// Event codes, the command record passed from front to back, constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

  typedef enum logic [1:0] {
    OP_HEAD  = 2'd0,
    OP_BODY  = 2'd1,
    OP_CHECK = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;
  localparam int unsigned US_PER_SEC = 1000000;
  localparam logic [19:0] INTERVAL_RESET = 20'd33333;

  // one classified event, front to back
  typedef struct packed {
    op_e         op;
    logic [63:0] now;
    logic [6:0]  idx;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/fds_front.sv
// ----------------------------------------------------------------------------
// fds_front: event intake
// Accepts events and queues them for the back end in a two-entry FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_front
  import fds_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [47:0] timestamp_us_i,
  input  wire logic [6:0]  bucket_index_i,
  output logic             busy_o,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_take_i
);

  cmd_t        fifo_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic [63:0] now;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o  = fifo_q[rd_q];

  // time taken modulo 2^TIME_BITS, from at most the 48 timestamp bits
  always_comb begin
    now = '0;
    for (int b = 0; b < TIME_BITS; b++) begin
      if (b < 48) now[b] = timestamp_us_i[b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (cmd_take_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= '{op: op_e'(opcode_i), now: now, idx: bucket_index_i};
  end

endmodule

`default_nettype wire

FILE: rtl/fds_div.sv
// ----------------------------------------------------------------------------
// fds_div: frame rate divider
// Restoring division of one million by the interval, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_div
  import fds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [19:0]      quot_o
);

  localparam logic [19:0] DIVIDEND = 20'(US_PER_SEC);

  logic [19:0] quot_q, dvd_q;
  logic [20:0] rem_q;
  logic [31:0] dsr_q;
  logic [4:0]  step_q;
  logic        run_q;
  logic [32:0] trial;

  assign trial  = {12'd0, rem_q[19:0], dvd_q[19]} - {1'b0, dsr_q};
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q  <= 1'b1;
        step_q <= 5'd0;
      end else if (run_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'd19) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q  <= DIVIDEND;
      rem_q  <= '0;
      quot_q <= '0;
      dsr_q  <= divisor_i;
    end else if (run_q) begin
      dvd_q <= {dvd_q[18:0], 1'b0};
      if (!trial[32]) begin
        rem_q  <= {1'b0, trial[19:0]};
        quot_q <= {quot_q[18:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[19:0], dvd_q[19]};
        quot_q <= {quot_q[18:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fds_back.sv
// ----------------------------------------------------------------------------
// fds_back: statistics engine
// Sequencer that closes frames, updates the tables and rescans the histogram.
// After reset it writes zero to every table entry before it takes an event.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_back
  import fds_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_take_o,
  output logic             result_valid_o,
  output logic             interrupted_o,
  output logic             frame_delayed_o,
  output logic             overflowed_o,
  output logic [31:0]      delivery_us_o,
  output logic [31:0]      gap_us_o,
  output logic [31:0]      interval_us_o,
  output logic [6:0]       fps_bucket_o,
  output logic [31:0]      time_adjust_us_o,
  output logic [6:0]       safe_threshold_o,
  output logic [6:0]       peak_bucket_o,
  output logic [31:0]      bucket_packet_count_o,
  output logic [31:0]      bucket_fps_count_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIFF, S_DIV, S_RDA, S_RDB, S_WR, S_RATE_RD, S_RATE_WR,
    S_SCAN, S_SCAN_END, S_READ, S_OUT
  } state_e;

  localparam logic [63:0] TMASK = (TIME_BITS >= 64) ? {64{1'b1}}
                                  : ((64'd1 << TIME_BITS) - 64'd1);

  // tables
  logic [31:0] phist_m [128];
  logic [31:0] rhist_m [128];
  logic [31:0] davg_m  [128];
  logic [31:0] gavg_m  [128];

  state_e      state_q;
  cmd_t        cmd_q;
  logic [19:0] ivl_cfg_q;
  logic [63:0] begin_q, end_q;
  logic        have_q, intr_q;
  logic [15:0] pkts_q, prev_q;
  logic [6:0]  peak_q, thr_q, last_q;
  logic [31:0] maxd_q, mind_q, best_q;
  logic [31:0] ovf_tot_q, dly_tot_q;
  logic [63:0] ivl_q;
  logic [31:0] dlv_q, gap_q;
  logic        late_q, ovf_q;
  logic [6:0]  fps_q, cidx_q, sidx_q, pidx_q, clr_q;
  logic [31:0] rd_p_q, rd_r_q, rd_d_q, rd_g_q;
  logic        scan_done_q;

  logic        div_go, div_done;
  logic [19:0] div_q;

  fds_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (div_go),
    .divisor_i(ivl_q[31:0]),
    .done_o   (div_done),
    .quot_o   (div_q)
  );

  // divide only when the interval is nonzero and small enough to matter
  assign div_go = (state_q == S_DIFF) && (ivl_q != 64'd0) && (ivl_q[63:32] == 32'd0);
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (v[63:32] != 32'd0) ? ALL32 : v[31:0];
  endfunction

  function automatic logic [31:0] havg(input logic [31:0] o, input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, o} + {1'b0, v};
    havg = (o == 32'd0) ? v : s[32:1];
  endfunction

  logic [63:0] endt, dlv64, gap64;
  logic [31:0] pe, re, de, ge;
  always_comb begin
    endt  = (pkts_q == 16'd1) ? begin_q : end_q;
    dlv64 = (endt - begin_q) & TMASK;
    gap64 = (cmd_q.now - endt) & TMASK;
    pe = rd_p_q;
    re = rd_r_q;
    de = rd_d_q;
    ge = rd_g_q;
  end

  // synchronous table reads and updates, clearing pass after reset
  always_ff @(posedge clk_i) begin
    rd_p_q <= phist_m[sidx_q];
    rd_d_q <= davg_m[cidx_q];
    rd_g_q <= gavg_m[cidx_q];
    rd_r_q <= rhist_m[fps_q];
    if (state_q == S_CLEAR) begin
      davg_m[clr_q]  <= '0;
      gavg_m[clr_q]  <= '0;
      phist_m[clr_q] <= '0;
      rhist_m[clr_q] <= '0;
    end else begin
      if (state_q == S_WR && !ovf_q) begin
        davg_m[cidx_q]  <= havg(de, dlv_q);
        gavg_m[cidx_q]  <= havg(ge, gap_q);
        phist_m[cidx_q] <= (pe == ALL32) ? pe : pe + 32'd1;
      end
      if (state_q == S_RATE_WR) rhist_m[fps_q] <= (re == ALL32) ? re : re + 32'd1;
    end
  end

  // sequencer, state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      ivl_cfg_q <= INTERVAL_RESET;
      begin_q <= '0; end_q <= '0; have_q <= 1'b0; intr_q <= 1'b1;
      pkts_q <= '0; prev_q <= '0; peak_q <= '0; thr_q <= '0; last_q <= '0;
      maxd_q <= '0; mind_q <= ALL32; best_q <= '0;
      ovf_tot_q <= '0; dly_tot_q <= '0;
      cmd_q <= '0; ivl_q <= '0; dlv_q <= '0; gap_q <= '0;
      late_q <= 1'b0; ovf_q <= 1'b0; fps_q <= '0; cidx_q <= '0; sidx_q <= '0;
      pidx_q <= '0;
      scan_done_q <= 1'b0;
      result_valid_o <= 1'b0;
      interrupted_o <= 1'b0; frame_delayed_o <= 1'b0; overflowed_o <= 1'b0;
      delivery_us_o <= '0; gap_us_o <= '0; interval_us_o <= '0; fps_bucket_o <= '0;
      time_adjust_us_o <= '0; safe_threshold_o <= '0; peak_bucket_o <= '0;
      bucket_packet_count_o <= '0; bucket_fps_count_o <= '0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) ivl_cfg_q <= cfg_wdata_i;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 7'd1;
          if (clr_q == 7'd127) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            case (cmd_i.op)
              OP_HEAD: begin
                if (have_q) begin
                  ivl_q <= (cmd_i.now - begin_q) & TMASK;
                  state_q <= S_DIFF;
                end else begin
                  begin_q <= cmd_i.now; have_q <= 1'b1; pkts_q <= 16'd1;
                  state_q <= S_OUT;
                end
              end
              OP_BODY: begin
                end_q <= cmd_i.now;
                if (pkts_q != 16'hFFFF) pkts_q <= pkts_q + 16'd1;
                state_q <= S_OUT;
              end
              OP_CHECK: begin
                intr_q <= ((cmd_i.now - begin_q) & TMASK) > {44'd0, ivl_cfg_q};
                best_q <= '0; last_q <= '0; sidx_q <= '0; scan_done_q <= 1'b0;
                state_q <= S_SCAN;
              end
              default: begin
                sidx_q <= cmd_i.idx; cidx_q <= cmd_i.idx; fps_q <= cmd_i.idx;
                state_q <= S_READ;
              end
            endcase
          end
        end
        S_DIFF: begin
          dlv_q  <= sat32(dlv64);
          gap_q  <= sat32(gap64);
          late_q <= ivl_q > {44'd0, ivl_cfg_q};
          ovf_q  <= pkts_q > 16'd127;
          cidx_q <= pkts_q[6:0];
          sidx_q <= pkts_q[6:0];
          if (ivl_q > {44'd0, ivl_cfg_q}) dly_tot_q <= dly_tot_q + 32'd1;
          if (ivl_q == 64'd0) begin
            fps_q <= 7'd127; state_q <= S_RDA;
          end else if (ivl_q[63:32] != 32'd0) begin
            fps_q <= 7'd0; state_q <= S_RDA;
          end else state_q <= S_DIV;
        end
        S_DIV: if (div_done) begin
          fps_q <= (div_q > 20'd127) ? 7'd127 : div_q[6:0];
          state_q <= S_RDA;
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          if (dlv_q > maxd_q) maxd_q <= dlv_q;
          if (dlv_q < mind_q) mind_q <= dlv_q;
          state_q <= S_WR;
        end
        S_WR: begin
          prev_q <= pkts_q;
          if (ovf_q) ovf_tot_q <= ovf_tot_q + 32'd1;
          begin_q <= cmd_q.now; pkts_q <= 16'd1;
          state_q <= ovf_q ? S_OUT : S_RATE_RD;
        end
        S_RATE_RD: state_q <= S_RATE_WR;
        S_RATE_WR: state_q <= S_OUT;
        S_SCAN: begin
          // pe holds the entry addressed in the previous cycle, tracked by pidx_q
          if (scan_done_q) begin
            if (pe > best_q) begin
              best_q <= pe;
              peak_q <= pidx_q;
            end
            if (pe != 32'd0) last_q <= pidx_q;
          end
          pidx_q <= sidx_q;
          sidx_q <= sidx_q + 7'd1;
          scan_done_q <= 1'b1;
          if (scan_done_q && pidx_q == 7'd127) state_q <= S_SCAN_END;
        end
        S_SCAN_END: begin
          thr_q <= 7'(({1'b0, last_q} + {1'b0, peak_q}) >> 1);
          state_q <= S_OUT;
        end
        S_READ: begin
          state_q <= S_OUT;
        end
        default: begin
          // S_OUT: present one result beat
          result_valid_o   <= 1'b1;
          interrupted_o    <= intr_q;
          frame_delayed_o  <= late_q;
          overflowed_o     <= ovf_q;
          interval_us_o    <= sat32(ivl_q);
          time_adjust_us_o <= ({9'd0, thr_q} > prev_q) ? mind_q : maxd_q;
          safe_threshold_o <= thr_q;
          peak_bucket_o    <= peak_q;
          if (cmd_q.op == OP_READ) begin
            delivery_us_o <= de; gap_us_o <= ge; fps_bucket_o <= '0;
            bucket_packet_count_o <= pe; bucket_fps_count_o <= re;
          end else begin
            delivery_us_o <= dlv_q; gap_us_o <= gap_q; fps_bucket_o <= fps_q;
            bucket_packet_count_o <= '0; bucket_fps_count_o <= '0;
          end
          // frame fields start from zero for the next event
          late_q <= 1'b0; ovf_q <= 1'b0; dlv_q <= '0; gap_q <= '0;
          ivl_q <= '0; fps_q <= '0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/frame_delivery_statistics.sv
// ----------------------------------------------------------------------------
// frame_delivery_statistics: per-frame delivery statistics engine
// Classifies timestamped packet events and keeps frame histograms and averages.
// ----------------------------------------------------------------------------
// Each event yields one result beat, strobed by result_valid_o for one cycle;
// the receiver cannot stall it. A body event or a head that opens the first
// frame goes straight to the result; a read first fetches the table entries;
// a head that closes a frame waits for the 20-step divider for the frame rate
// (no division runs when the interval is zero or at least 2^32, and the tables
// are left alone when the packet count overflows); a check runs the
// one-entry-per-cycle rescan of the 128-bucket packet histogram. After reset
// the back end clears its tables before it takes the first event. A two-entry
// queue in front lets start be taken while the back end works; busy is high
// only when that queue is full.
`default_nettype none

module frame_delivery_statistics
  import fds_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [47:0] timestamp_us_i,
  input  wire logic [6:0]  bucket_index_i,
  output logic             result_valid_o,
  output logic             interrupted_o,
  output logic             frame_delayed_o,
  output logic             overflowed_o,
  output logic [31:0]      delivery_us_o,
  output logic [31:0]      gap_us_o,
  output logic [31:0]      interval_us_o,
  output logic [6:0]       fps_bucket_o,
  output logic [31:0]      time_adjust_us_o,
  output logic [6:0]       safe_threshold_o,
  output logic [6:0]       peak_bucket_o,
  output logic [31:0]      bucket_packet_count_o,
  output logic [31:0]      bucket_fps_count_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  fds_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni,
    .start_i(start), .opcode_i, .timestamp_us_i, .bucket_index_i,
    .busy_o(busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  fds_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .result_valid_o, .interrupted_o, .frame_delayed_o, .overflowed_o,
    .delivery_us_o, .gap_us_o, .interval_us_o, .fps_bucket_o,
    .time_adjust_us_o, .safe_threshold_o, .peak_bucket_o,
    .bucket_packet_count_o, .bucket_fps_count_o
  );

endmodule

`default_nettype wire

FILE: tb/sv/fds_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fds_checker: scoreboard for the frame delivery statistics block
// Watches accepted events and result beats, predicts each result from its own
// copy of the histograms, averages and frame state, and compares per field.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_checker
  import fds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [47:0] timestamp_us_i,
  input  wire logic [6:0]  bucket_index_i,
  input  wire logic        result_valid_o,
  input  wire logic        interrupted_o,
  input  wire logic        frame_delayed_o,
  input  wire logic        overflowed_o,
  input  wire logic [31:0] delivery_us_o,
  input  wire logic [31:0] gap_us_o,
  input  wire logic [31:0] interval_us_o,
  input  wire logic [6:0]  fps_bucket_o,
  input  wire logic [31:0] time_adjust_us_o,
  input  wire logic [6:0]  safe_threshold_o,
  input  wire logic [6:0]  peak_bucket_o,
  input  wire logic [31:0] bucket_packet_count_o,
  input  wire logic [31:0] bucket_fps_count_o,
  output int               fail_count,
  output int               pending_count,
  output int               beat_count
);

  typedef struct packed {
    logic        intr;
    logic        late;
    logic        ovf;
    logic [31:0] dlv;
    logic [31:0] gap;
    logic [31:0] ivl;
    logic [6:0]  fps;
    logic [31:0] adj;
    logic [6:0]  thr;
    logic [6:0]  peak;
    logic [31:0] pkt_cnt;
    logic [31:0] fps_cnt;
  } stats_t;

  // predicted state
  logic [31:0] pkt_hist [128];
  logic [31:0] dlv_avg [128];
  logic [31:0] gap_avg [128];
  logic [31:0] fps_hist [128];
  logic [47:0] begin_ts, end_ts;
  logic        open_frame;
  logic [15:0] pkts, prev_pkts;
  logic [6:0]  peak_idx, thr_idx;
  logic [31:0] dlv_max, dlv_min;
  logic        intr_flag;
  logic [19:0] expect_ivl;

  stats_t expected_q[$];

  function automatic logic [31:0] sat32(logic [47:0] v);
    return (v > 48'hFFFF_FFFF) ? ALL32 : v[31:0];
  endfunction

  function automatic logic [31:0] halve(logic [31:0] old, logic [31:0] val);
    logic [32:0] s;
    s = {1'b0, old} + {1'b0, val};
    return (old == 0) ? val : s[32:1];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == ALL32) ? v : v + 1;
  endfunction

  task automatic predict_event(input op_e op, input logic [47:0] now,
                               input logic [6:0] idx);
    stats_t r;
    logic [47:0] fin, ivl;
    logic [31:0] dlv, gp;
    logic [47:0] q;
    logic [6:0]  fps;
    logic [31:0] best;
    logic [6:0]  last;
    logic [7:0]  mid;
    r = '0;
    case (op)
      OP_HEAD: begin
        if (open_frame) begin
          fin = (pkts == 1) ? begin_ts : end_ts;
          ivl = now - begin_ts;
          dlv = sat32(fin - begin_ts);
          gp  = sat32(now - fin);
          if (ivl == 0) fps = 7'd127;
          else begin
            q = 48'(US_PER_SEC) / ivl;
            fps = (q > 127) ? 7'd127 : q[6:0];
          end
          if (dlv > dlv_max) dlv_max = dlv;
          if (dlv < dlv_min) dlv_min = dlv;
          if (pkts <= 127) begin
            dlv_avg[pkts] = halve(dlv_avg[pkts], dlv);
            gap_avg[pkts] = halve(gap_avg[pkts], gp);
            pkt_hist[pkts] = bump(pkt_hist[pkts]);
            fps_hist[fps] = bump(fps_hist[fps]);
          end
          prev_pkts = pkts;
          r.late = ivl > {28'd0, expect_ivl};
          r.ovf  = pkts > 127;
          r.dlv  = dlv;
          r.gap  = gp;
          r.ivl  = sat32(ivl);
          r.fps  = fps;
        end
        begin_ts = now;
        open_frame = 1'b1;
        pkts = 1;
      end
      OP_BODY: begin
        end_ts = now;
        if (pkts != 16'hFFFF) pkts = pkts + 1;
      end
      OP_CHECK: begin
        intr_flag = (now - begin_ts) > {28'd0, expect_ivl};
        best = 0;
        last = 0;
        for (int i = 0; i < 128; i++) begin
          if (pkt_hist[i] > best) begin
            best = pkt_hist[i];
            peak_idx = 7'(i);
          end
          if (pkt_hist[i] != 0) last = 7'(i);
        end
        mid = ({1'b0, last} + {1'b0, peak_idx}) >> 1;
        thr_idx = mid[6:0];
      end
      default: begin
        r.dlv = dlv_avg[idx];
        r.gap = gap_avg[idx];
        r.pkt_cnt = pkt_hist[idx];
        r.fps_cnt = fps_hist[idx];
      end
    endcase
    r.intr = intr_flag;
    r.adj  = (prev_pkts < {9'd0, thr_idx}) ? dlv_min : dlv_max;
    r.thr  = thr_idx;
    r.peak = peak_idx;
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [31:0] e, input logic [31:0] a);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch beat %0d %s: expected %0h got %0h", beat_count, what, e, a);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 128; i++) begin
        pkt_hist[i] = 0;
        dlv_avg[i] = 0;
        gap_avg[i] = 0;
        fps_hist[i] = 0;
      end
      begin_ts = 0;
      end_ts = 0;
      open_frame = 0;
      pkts = 0;
      prev_pkts = 0;
      peak_idx = 0;
      thr_idx = 0;
      dlv_max = 0;
      dlv_min = ALL32;
      intr_flag = 1;
      expect_ivl = INTERVAL_RESET;
      expected_q.delete();
      fail_count = 0;
      pending_count = 0;
      beat_count = 0;
    end else begin
      // result beat: compare against the oldest prediction
      if (result_valid_o) begin
        beat_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %0d", beat_count);
        end else begin
          e = expected_q.pop_front();
          if (e.intr != interrupted_o) report("interrupted", e.intr, interrupted_o);
          if (e.late != frame_delayed_o) report("frame_delayed", e.late, frame_delayed_o);
          if (e.ovf != overflowed_o) report("overflowed", e.ovf, overflowed_o);
          if (e.dlv != delivery_us_o) report("delivery", e.dlv, delivery_us_o);
          if (e.gap != gap_us_o) report("gap", e.gap, gap_us_o);
          if (e.ivl != interval_us_o) report("interval", e.ivl, interval_us_o);
          if (e.fps != fps_bucket_o) report("fps_bucket", e.fps, fps_bucket_o);
          if (e.adj != time_adjust_us_o) report("time_adjust", e.adj, time_adjust_us_o);
          if (e.thr != safe_threshold_o) report("threshold", e.thr, safe_threshold_o);
          if (e.peak != peak_bucket_o) report("peak", e.peak, peak_bucket_o);
          if (e.pkt_cnt != bucket_packet_count_o)
            report("packet_count", e.pkt_cnt, bucket_packet_count_o);
          if (e.fps_cnt != bucket_fps_count_o)
            report("fps_count", e.fps_cnt, bucket_fps_count_o);
        end
      end
      if (cfg_we_i) expect_ivl = cfg_wdata_i;
      // accepted event beat
      if (start && !busy)
        predict_event(op_e'(opcode_i), timestamp_us_i, bucket_index_i);
      pending_count = expected_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: frame delivery statistics stimulus and verdict
// Drives directed and random frame sequences under several expected
// intervals; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import fds_pkg::*;
();

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [19:0] cfg_wdata_i = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  opcode_i = 0;
  logic [47:0] timestamp_us_i = 0;
  logic [6:0]  bucket_index_i = 0;
  logic        result_valid_o, interrupted_o, frame_delayed_o, overflowed_o;
  logic [31:0] delivery_us_o, gap_us_o, interval_us_o, time_adjust_us_o;
  logic [6:0]  fps_bucket_o, safe_threshold_o, peak_bucket_o;
  logic [31:0] bucket_packet_count_o, bucket_fps_count_o;
  int          fail_count, pending_count, beat_count;

  logic [47:0] clock_us;
  int          event_total;
  bit          quiet;

  always #2 clk_i = ~clk_i;

  frame_delivery_statistics uut (.*);
  fds_checker checker_i (.*);

  // one event beat, held until taken; start stays high into the next beat
  task automatic send_event(input op_e op, input logic [47:0] ts, input logic [6:0] idx);
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        start <= 0;
        @(posedge clk_i);
      end
    end
    start <= 1;
    opcode_i <= op;
    timestamp_us_i <= ts;
    bucket_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    event_total++;
  endtask

  task automatic drain();
    start <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_interval(input logic [19:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // a frame: head then some body packets at advancing times
  task automatic send_frame(input int body, input int step);
    send_event(OP_HEAD, clock_us, 7'($urandom));
    for (int i = 0; i < body; i++) begin
      clock_us = clock_us + $urandom_range(step);
      send_event(OP_BODY, clock_us, 7'($urandom));
    end
    clock_us = clock_us + $urandom_range(step * 4);
  endtask

  task automatic random_phase(input int n, input int step);
    int k;
    int nb;
    k = 0;
    while (k < n) begin
      quiet = (k > n / 2) && (k < n / 2 + 60);
      case ($urandom_range(9))
        0: begin
          send_event(OP_CHECK, clock_us + $urandom_range(step * 3), 7'd0);
          k++;
        end
        1: begin
          send_event(OP_READ, 48'd0, 7'($urandom_range(12)));
          k++;
        end
        2: begin
          send_event(op_e'($urandom_range(3)), 48'({$urandom, $urandom}), 7'($urandom));
          k++;
        end
        default: begin
          nb = $urandom_range(6);
          send_frame(nb, step);
          k = k + 1 + nb;
        end
      endcase
    end
    quiet = 0;
  endtask

  initial begin
    event_total = 0;
    quiet = 0;
    clock_us = 48'd1000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty state, lone head frames, zero interval, extremes
    send_event(OP_CHECK, 48'hFFFF_FFFF_FFFF, 7'd0);
    send_event(OP_READ, 48'd0, 7'd127);
    send_event(OP_BODY, 48'd5, 7'd0);
    send_event(OP_HEAD, 48'd0, 7'd0);
    send_event(OP_HEAD, 48'd0, 7'd0);
    send_event(OP_HEAD, 48'd40000, 7'd0);
    send_event(OP_BODY, 48'd40010, 7'd0);
    send_event(OP_BODY, 48'd40300, 7'd0);
    send_event(OP_HEAD, 48'hFFFF_FFFF_FFFF, 7'd0);
    send_event(OP_BODY, 48'd20, 7'd0);
    send_event(OP_HEAD, 48'd100, 7'd0);
    send_event(OP_CHECK, 48'd150, 7'd0);
    send_event(OP_READ, 48'd0, 7'd1);
    send_event(OP_READ, 48'd0, 7'd3);
    send_event(OP_READ, 48'd0, 7'd127);
    // overflowing packet count
    for (int i = 0; i < 130; i++) send_event(OP_BODY, 48'd200 + i, 7'd0);
    send_event(OP_HEAD, 48'h8000_0000_0000, 7'd0);
    send_event(OP_CHECK, 48'h8000_0000_0001, 7'd0);
    send_event(OP_READ, 48'd0, 7'd2);

    // sweep the expected interval across its range
    set_interval(20'd1);
    random_phase(230, 50);
    set_interval(20'hFFFFF);
    random_phase(230, 200000);
    set_interval(20'd1000000 & 20'hFFFFF);
    random_phase(230, 40000);
    set_interval(20'd500);
    random_phase(260, 800);

    drain();
    $display("ran %0d events, %0d result beats, four expected-interval settings",
             event_total, beat_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
